>>> rtl/cpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_pkg: shared types and constants of the checked packet deframer
// Transfer types on both channels, item kind and status codes, and the
// frame layout constants.
// ----------------------------------------------------------------------------
package cpd_pkg;

  // Frame layout
  localparam int unsigned POS_W      = 9;    // byte position counter width
  localparam int unsigned HDR_BYTES  = 5;    // dest, src, id, type, length
  localparam int unsigned HDR_IDX_W  = 3;    // index into the header bytes
  localparam int unsigned LEN_IDX    = 4;    // header byte holding the length
  localparam int unsigned MIN_LAST   = 6;    // lowest legal index of the final byte
  localparam int unsigned POS_TOP    = 510;  // position saturates here, toggling parity

  // Kind of an output transfer
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_REPORT  = 1'b1
  } kind_e;

  // Frame completion status
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_SUM = 2'd1,
    STATUS_SHORT   = 2'd2
  } status_e;

  // Input transfer payload
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } in_t;

  // Output transfer payload
  typedef struct packed {
    kind_e      item_kind;
    logic [7:0] payload_value;
    logic [7:0] frame_dest;
    logic [7:0] frame_src;
    logic [7:0] frame_id;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    status_e    frame_status;
  } out_t;

  // Registered input byte handed to the core
  typedef struct packed {
    logic valid;
    in_t  data;
  } in_stage_t;

  // Result of one byte, as presented to the output register
  typedef struct packed {
    logic valid;
    out_t data;
  } res_stage_t;

endpackage

>>> rtl/checked_packet_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_packet_deframer_top: byte-stream frame deframer with checksum check
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one frame byte
//   per transfer, end_of_frame set on the final byte. Bytes 0..4 are header
//   (dest, src, id, type, length); the following length bytes come out as
//   payload transfers; the last two bytes are a big-endian checksum.
//   Output channel (out_valid_o / out_ready_i / out_data_o) gives a payload
//   transfer per payload byte and one completion report per frame, with the
//   header and a status: ok, checksum mismatch, or short frame.
//   Each byte passes the input register, then the output register, before
//   its result raises out_valid_o. Throughput: one byte per cycle while the
//   receiver takes results. Reset clears position, checksum, delay bytes,
//   header and the valid flags of both registers.
//   When the receiver stalls, the held result stays in the output register;
//   one more byte waits in the input register, then in_ready_o drops.
// ----------------------------------------------------------------------------
module checked_packet_deframer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cpd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cpd_pkg::out_t out_data_o
);
  import cpd_pkg::*;

  in_stage_t  stage;
  res_stage_t res;
  logic       advance;

  // Core consumes the held byte when the output register can take a result
  assign advance = stage.valid && (!out_valid_o || out_ready_i);

  cpd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .stage_o    (stage)
  );

  cpd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_i (advance),
    .res_o     (res)
  );

  cpd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .advance_i   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/cpd_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_in_reg: input register stage
// Captures one byte per cycle while free; the core consumes it on advance.
// ----------------------------------------------------------------------------
module cpd_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cpd_pkg::in_t      in_data_i,
  input  logic              advance_i,
  output cpd_pkg::in_stage_t stage_o
);
  import cpd_pkg::*;

  logic valid_q, valid_d;
  in_t  data_q;

  // Free when empty or when the held byte is consumed this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

>>> rtl/cpd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_core: frame state and per-byte deframing logic
// Tracks byte position, header bytes and the ones'-complement checksum, and
// forms the payload or completion result for the registered byte.
// ----------------------------------------------------------------------------
module cpd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpd_pkg::in_stage_t  stage_i,
  input  logic                advance_i,
  output cpd_pkg::res_stage_t res_o
);
  import cpd_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       dly_q [2];
  logic [7:0]       dly_d [2];
  logic [7:0]       hdr_q [HDR_BYTES];
  logic [7:0]       hdr_d [HDR_BYTES];

  logic [7:0]  cur_byte;
  logic        cur_last;
  logic [15:0] add_word;
  logic [16:0] sum_t1;
  logic [15:0] sum_1;
  logic [15:0] sum_a;
  logic [15:0] corr_word;
  logic [16:0] sum_t2;
  logic [15:0] sum_2;
  logic [15:0] sum_f;
  logic        do_corr;
  logic [15:0] rx_sum;
  logic        pos_short;
  logic        pos_in_hdr;
  logic [POS_W-1:0] pay_idx;
  logic        is_payload;
  status_e     status;

  assign cur_byte = stage_i.data.rx_byte;
  assign cur_last = stage_i.data.end_of_frame;

  // Byte two back is data: add it as high byte at even index, low at odd
  assign add_word = pos_q[0] ? {8'h00, dly_q[1]} : {dly_q[1], 8'h00};
  assign sum_t1   = {1'b0, sum_q} + {1'b0, add_word};
  assign sum_1    = sum_t1[15:0] + {15'd0, sum_t1[16]};
  assign sum_a    = (pos_q >= POS_W'(2)) ? sum_1 : sum_q;

  // Unpaired trailing byte: take back the high-byte add, keep it as low byte
  assign do_corr   = !pos_q[0] && (dly_q[1] != 8'h00);
  assign corr_word = 16'hFFFF - ({dly_q[1], 8'h00} - {8'h00, dly_q[1]});
  assign sum_t2    = {1'b0, sum_a} + {1'b0, corr_word};
  assign sum_2     = sum_t2[15:0] + {15'd0, sum_t2[16]};
  assign sum_f     = do_corr ? sum_2 : sum_a;

  // Received checksum, big-endian
  assign rx_sum    = {dly_q[0], cur_byte};

  assign pos_short  = pos_q < POS_W'(MIN_LAST);
  assign pos_in_hdr = pos_q < POS_W'(HDR_BYTES);
  assign pay_idx    = pos_q - POS_W'(HDR_BYTES);
  assign is_payload = !pos_in_hdr && (pos_q < POS_W'(POS_TOP))
                      && (pay_idx < {1'b0, hdr_q[LEN_IDX]});

  // Header capture including the current byte
  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_d[i] = hdr_q[i];
    end
    if (pos_in_hdr) begin
      hdr_d[pos_q[HDR_IDX_W-1:0]] = cur_byte;
    end
  end

  // Completion status
  always_comb begin
    if (pos_short) begin
      status = STATUS_SHORT;
    end else if (~sum_f == rx_sum) begin
      status = STATUS_OK;
    end else begin
      status = STATUS_BAD_SUM;
    end
  end

  // Result for the registered byte
  always_comb begin
    res_o.data = '0;
    res_o.valid = stage_i.valid && (cur_last || is_payload);
    if (cur_last) begin
      res_o.data.item_kind    = KIND_REPORT;
      res_o.data.frame_dest   = hdr_d[0];
      res_o.data.frame_src    = hdr_d[1];
      res_o.data.frame_id     = hdr_d[2];
      res_o.data.frame_type   = hdr_d[3];
      res_o.data.frame_length = hdr_d[4];
      res_o.data.frame_status = status;
    end else begin
      res_o.data.item_kind     = KIND_PAYLOAD;
      res_o.data.payload_value = cur_byte;
    end
  end

  // Next position: count up, then toggle between the top two values
  always_comb begin
    if (pos_q < POS_W'(POS_TOP)) begin
      pos_d = pos_q + POS_W'(1);
    end else begin
      pos_d = pos_q ^ POS_W'(1);
    end
  end

  assign sum_d    = sum_a;
  assign dly_d[0] = cur_byte;
  assign dly_d[1] = dly_q[0];

  // Frame state; cleared after each completion report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      for (int i = 0; i < 2; i++) begin
        dly_q[i] <= '0;
      end
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_q[i] <= '0;
      end
    end else if (advance_i) begin
      if (cur_last) begin
        pos_q <= '0;
        sum_q <= '0;
        for (int i = 0; i < 2; i++) begin
          dly_q[i] <= '0;
        end
        for (int i = 0; i < HDR_BYTES; i++) begin
          hdr_q[i] <= '0;
        end
      end else begin
        pos_q <= pos_d;
        sum_q <= sum_d;
        for (int i = 0; i < 2; i++) begin
          dly_q[i] <= dly_d[i];
        end
        for (int i = 0; i < HDR_BYTES; i++) begin
          hdr_q[i] <= hdr_d[i];
        end
      end
    end
  end

  // A completion report restarts the frame
  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && cur_last) |=> (pos_q == '0 && sum_q == '0))
    else $error("position or sum not cleared after report");

  // Position saturates toggling between the top two values
  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && !cur_last && pos_q >= POS_W'(POS_TOP)) |=> (pos_q[POS_W-1:1] == '1))
    else $error("byte position left its saturation range");

  // Payload only after the header and before saturation
  a_payload_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.item_kind == KIND_PAYLOAD)
      |-> (pos_q >= POS_W'(HDR_BYTES) && pos_q < POS_W'(POS_TOP)))
    else $error("payload result outside payload window");

  // Short status only for frames ending early
  a_short_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.item_kind == KIND_REPORT
      && res_o.data.frame_status == STATUS_SHORT) |-> pos_short)
    else $error("short status on a full-size frame");

endmodule

>>> rtl/cpd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_out_reg: output result register
// Holds one result transfer until the receiver takes it.
// ----------------------------------------------------------------------------
module cpd_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpd_pkg::res_stage_t res_i,
  input  logic                advance_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cpd_pkg::out_t       out_data_o
);
  import cpd_pkg::*;

  logic valid_q, valid_d;
  out_t data_q;
  logic load;

  assign load = advance_i && res_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i.data;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: checked packet deframer, self-checking
// Feeds byte-stream frames into the deframer: a short directed list
// (short frames, all-zero frames with good and bad checksum, payload
// extremes), then random frames: well formed, wrong length field, cut off
// inside the payload, noise and one overlong frame. A local copy of the
// deframer state predicts every payload and report transfer, and each output
// transfer is compared field by field with the oldest expected one. Both
// channels stall in random bursts; the receiver also holds off once for a
// long stretch and the sender once waits for the output to drain.
// ----------------------------------------------------------------------------
module testbench;
  import cpd_pkg::*;

  localparam int ITEM_TARGET   = 1950;  // input bytes to send in total
  localparam int CALM_ITEMS    = 150;   // last bytes sent without any stalls
  localparam int HOLD_AT       = 500;   // byte count that starts the long hold
  localparam int HOLD_CYCLES   = 60;    // receiver hold-off, in cycles
  localparam int PAUSE_AT      = 1300;  // byte count of the sender pause
  localparam int OVERLONG_AT   = 900;   // byte count after which one huge frame goes
  localparam int DRAIN_CYCLES  = 10;    // quiet cycles after the last result
  localparam int STALL_LIMIT   = 2000;  // cycles without a transfer before giving up

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHK_PREDICT,  // expectation comes from the deframe predictor
    CHK_NONE,     // byte gives no result
    CHK_FIXED     // expectation typed into the row
  } check_e;

  typedef struct {
    in_t    item;
    check_e check;
    out_t   want;
  } stim_row_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  in_t   in_data_i   = '0;
  logic  out_ready_i = 1'b0;
  logic  in_ready_o;
  logic  out_valid_o;
  out_t  out_data_o;

  // Predictor state: a copy of the deframer's own registers
  logic [8:0]  frame_pos;
  logic [16:0] csum;
  logic [7:0]  prev_byte [2];   // [0] last byte, [1] the one before
  logic [7:0]  hdr_bytes [5];

  out_t      expected_results[$];
  stim_row_t directed_rows[$];
  in_t       frame_bytes[$];
  int        sent_count = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;      // no stalls on either side
  bit        idle_on = 1'b1;   // sender may idle in the current frame
  bit        rx_stall_on = 1'b1;
  bit        hold_done = 1'b0;

  checked_packet_deframer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Ones'-complement add with end-around carry
  function automatic logic [16:0] fold16(input logic [16:0] s, input int unsigned a);
    int unsigned t;
    t = s + a;
    return 17'((t & 32'hFFFF) + (t >> 16));
  endfunction

  function automatic void clear_tracker();
    frame_pos = '0;
    csum      = '0;
    prev_byte = '{default: '0};
    hdr_bytes = '{default: '0};
  endfunction

  // Advance the deframer copy by one byte; returns 1 when a result is due
  function automatic bit deframe_byte(input in_t item, output out_t res);
    logic [8:0]  p;
    logic [15:0] rx_word;
    logic [15:0] calc;
    int unsigned corr;
    status_e     st;
    p   = frame_pos;
    res = '0;
    // byte two back is data now: even index is the high byte of a word
    if (p >= 2)
      csum = fold16(csum, p[0] ? {24'd0, prev_byte[1]} : {16'd0, prev_byte[1], 8'd0});
    if (p < HDR_BYTES)
      hdr_bytes[p[2:0]] = item.rx_byte;
    if (item.end_of_frame) begin
      if (p < MIN_LAST) begin
        st = STATUS_SHORT;
      end else begin
        // unpaired trailing data byte belongs in the low half: take back 255*d
        if (!p[0] && prev_byte[1] != 8'd0) begin
          corr = 32'hFFFF - 255 * int'(prev_byte[1]);
          csum = fold16(csum, corr);
        end
        rx_word = {prev_byte[0], item.rx_byte};
        calc    = 16'hFFFF - csum[15:0];
        st      = (calc == rx_word) ? STATUS_OK : STATUS_BAD_SUM;
      end
      res.item_kind    = KIND_REPORT;
      res.frame_dest   = hdr_bytes[0];
      res.frame_src    = hdr_bytes[1];
      res.frame_id     = hdr_bytes[2];
      res.frame_type   = hdr_bytes[3];
      res.frame_length = hdr_bytes[LEN_IDX];
      res.frame_status = st;
      clear_tracker();
      return 1'b1;
    end
    prev_byte[1] = prev_byte[0];
    prev_byte[0] = item.rx_byte;
    frame_pos    = (p < POS_TOP) ? p + 9'd1 : p ^ 9'd1;
    if (p >= HDR_BYTES && p < POS_TOP && (p - HDR_BYTES) < hdr_bytes[LEN_IDX]) begin
      res.item_kind     = KIND_PAYLOAD;
      res.payload_value = item.rx_byte;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic in_t mk_byte(input logic [7:0] b, input logic eof);
    in_t x;
    x.rx_byte      = b;
    x.end_of_frame = eof;
    return x;
  endfunction

  function automatic out_t mk_report(input logic [7:0] dest, input logic [7:0] src,
                                     input logic [7:0] id, input logic [7:0] typ,
                                     input logic [7:0] len, input status_e st);
    out_t r;
    r              = '0;
    r.item_kind    = KIND_REPORT;
    r.frame_dest   = dest;
    r.frame_src    = src;
    r.frame_id     = id;
    r.frame_type   = typ;
    r.frame_length = len;
    r.frame_status = st;
    return r;
  endfunction

  function automatic out_t mk_payload(input logic [7:0] v);
    out_t r;
    r               = '0;
    r.item_kind     = KIND_PAYLOAD;
    r.payload_value = v;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic eof,
                                  input check_e check, input out_t want);
    stim_row_t r;
    r.item  = mk_byte(b, eof);
    r.check = check;
    r.want  = want;
    directed_rows.push_back(r);
  endfunction

  // Header with the given length field, n_data payload bytes, then the
  // big-endian checksum, optionally corrupted
  function automatic void build_frame(input int n_data, input logic [7:0] len_field,
                                      input bit corrupt);
    logic [7:0]  data[$];
    logic [16:0] sum;
    logic [15:0] word;
    int          i;
    data = {};
    for (i = 0; i < HDR_BYTES; i++)
      data.push_back(i == LEN_IDX ? len_field : 8'($urandom_range(0, 255)));
    for (i = 0; i < n_data; i++)
      data.push_back(8'($urandom_range(0, 255)));
    sum = '0;
    for (i = 0; i < data.size(); i++) begin
      if (i % 2 == 0 && i + 1 < data.size())
        sum = fold16(sum, {16'd0, data[i], 8'd0});
      else
        sum = fold16(sum, {24'd0, data[i]});
    end
    word = ~sum[15:0];
    if (corrupt)
      word = word ^ 16'($urandom_range(1, 65535));
    frame_bytes = {};
    foreach (data[j])
      frame_bytes.push_back(mk_byte(data[j], 1'b0));
    frame_bytes.push_back(mk_byte(word[15:8], 1'b0));
    frame_bytes.push_back(mk_byte(word[7:0], 1'b1));
  endfunction

  // Offer one byte, wait for its transfer, then record what it should produce
  task automatic offer_byte(input in_t item, input check_e check, input out_t want);
    out_t res;
    bit   has_res;
    if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    has_res = deframe_byte(item, res);
    if (check == CHK_FIXED)
      expected_results.push_back(want);
    else if (check == CHK_PREDICT && has_res)
      expected_results.push_back(res);
    sent_count++;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Output side: compare each transfer with the oldest expectation
  always @(posedge clk_i) begin : out_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("item_kind", want.item_kind, out_data_o.item_kind);
        check_field("payload_value", want.payload_value, out_data_o.payload_value);
        check_field("frame_dest", want.frame_dest, out_data_o.frame_dest);
        check_field("frame_src", want.frame_src, out_data_o.frame_src);
        check_field("frame_id", want.frame_id, out_data_o.frame_id);
        check_field("frame_type", want.frame_type, out_data_o.frame_type);
        check_field("frame_length", want.frame_length, out_data_o.frame_length);
        check_field("frame_status", want.frame_status, out_data_o.frame_status);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, steady at the end
  initial begin : receiver
    wait (rst_ni);
    forever begin
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && rx_stall_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
      if ($urandom_range(0, 99) == 0)
        rx_stall_on = !rx_stall_on;
    end
  end

  initial begin : main
    int         pick;
    int         n_data;
    int         cut;
    int         sz;
    bit         overlong_done;
    bit         paused;
    in_t        b;
    overlong_done = 1'b0;
    paused        = 1'b0;
    clear_tracker();

    // short frames: report carries whatever header arrived
    add_row(8'hAB, 1'b1, CHK_FIXED, mk_report(8'hAB, 8'h00, 8'h00, 8'h00, 8'h00,
                                              STATUS_SHORT));
    add_row(8'hFF, 1'b0, CHK_NONE, '0);
    add_row(8'hFF, 1'b1, CHK_FIXED, mk_report(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                                              STATUS_SHORT));
    // all-zero header, zero length: checksum 0xFFFF is good, 0x0000 is bad
    repeat (5) add_row(8'h00, 1'b0, CHK_NONE, '0);
    add_row(8'hFF, 1'b0, CHK_NONE, '0);
    add_row(8'hFF, 1'b1, CHK_FIXED, mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                              STATUS_OK));
    repeat (5) add_row(8'h00, 1'b0, CHK_NONE, '0);
    add_row(8'h00, 1'b0, CHK_NONE, '0);
    add_row(8'h00, 1'b1, CHK_FIXED, mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                              STATUS_BAD_SUM));
    // all-ones header bytes, length 2, two payload bytes at the extremes
    repeat (4) add_row(8'hFF, 1'b0, CHK_NONE, '0);
    add_row(8'h02, 1'b0, CHK_NONE, '0);
    add_row(8'h00, 1'b0, CHK_FIXED, mk_payload(8'h00));
    add_row(8'hFF, 1'b0, CHK_FIXED, mk_payload(8'hFF));
    add_row(8'h12, 1'b0, CHK_NONE, '0);
    add_row(8'h34, 1'b1, CHK_PREDICT, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r])
      offer_byte(directed_rows[r].item, directed_rows[r].check, directed_rows[r].want);

    // let the directed results drain before the random frames
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);

    while (sent_count < ITEM_TARGET) begin
      sz     = $urandom_range(0, 19);
      n_data = (sz < 14) ? $urandom_range(0, 12) :
               (sz < 19) ? $urandom_range(13, 60) : $urandom_range(61, 255);
      pick   = $urandom_range(0, 99);
      if (!overlong_done && sent_count > OVERLONG_AT) begin
        // runs the position counter into its saturating range
        overlong_done = 1'b1;
        build_frame(POS_TOP, 8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 65) begin
        build_frame(n_data, 8'(n_data), $urandom_range(0, 7) == 0);
      end else if (pick < 75) begin
        // length field unrelated to the bytes that follow
        build_frame(n_data, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else if (pick < 87) begin
        // frame cut off with the end flag on a payload byte
        build_frame(n_data + 1, 8'(n_data + 1), 1'b0);
        cut = $urandom_range(MIN_LAST, HDR_BYTES + n_data + 1);
        while (frame_bytes.size() > cut) b = frame_bytes.pop_back();
        b = frame_bytes.pop_back();
        b.end_of_frame = 1'b1;
        frame_bytes.push_back(b);
      end else begin
        // noise: a few random bytes, mostly too short for a frame
        frame_bytes = {};
        sz = $urandom_range(1, 8);
        for (int i = 0; i < sz; i++)
          frame_bytes.push_back(mk_byte(8'($urandom_range(0, 255)), i == sz - 1));
      end

      idle_on = ($urandom_range(0, 2) != 0);
      calm    = (sent_count >= ITEM_TARGET - CALM_ITEMS);
      foreach (frame_bytes[j])
        offer_byte(frame_bytes[j], CHK_PREDICT, '0);

      if (!paused && sent_count >= PAUSE_AT) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (expected_results.size() != 0);
      end
    end

    // drain, then a few quiet cycles to catch stray results
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
